[hw/rtl/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and constants for the meter telegram framer
// Beat layouts, opcode and status codes, register indexes and store sizing.
// ----------------------------------------------------------------------------
package mtf_pkg;

    // Sizing of line length and telegram store
    localparam int LINE_CAPACITY     = 1024;
    localparam int TELEGRAM_CAPACITY = 2048;

    // Line byte counter holds 0 .. LINE_CAPACITY-1
    localparam int LINE_CNT_W = $clog2(LINE_CAPACITY);
    // Store address
    localparam int STORE_AW   = $clog2(TELEGRAM_CAPACITY);
    // Stored length holds 0 .. TELEGRAM_CAPACITY
    localparam int LEN_W      = $clog2(TELEGRAM_CAPACITY + 1);
    // Store position / appended length: base + line count + newline
    localparam int POS_W      = $clog2(TELEGRAM_CAPACITY + LINE_CAPACITY + 1);

    // Fixed field widths
    localparam int IDLE_W     = 16;
    localparam int MAX_LEN_W  = 12;
    localparam int OUT_LEN_W  = 12;
    localparam int INDEX_W    = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Width used for length limit compares
    localparam int CMP_W = (POS_W > MAX_LEN_W) ? POS_W : MAX_LEN_W;

    // Register reset values
    localparam logic [IDLE_W-1:0]    IDLE_LIMIT_RST = IDLE_W'(30000);
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST    = MAX_LEN_W'(2048);

    // Character codes
    localparam logic [7:0] CH_START = 8'h2F;
    localparam logic [7:0] CH_END   = 8'h21;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 1'b1;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } mtf_op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DROP = 2'd1,
        ST_IDLE = 2'd2,
        ST_READ = 2'd3
    } mtf_status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] read_index;
    } mtf_in_t;

    typedef struct packed {
        mtf_status_t          status;
        logic [OUT_LEN_W-1:0] telegram_length;
        logic [7:0]           read_byte;
    } mtf_out_t;

endpackage

[hw/rtl/meter_telegram_framer_core.sv]
// ----------------------------------------------------------------------------
// meter_telegram_framer_core: smart-meter telegram framer
// Collects received bytes into lines, frames telegrams between a '/' line
// and a '!' line in an on-chip store, times out idle telegrams and serves
// byte reads of the stored telegram.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              payload
//  -------   ---   --------------------   ------------------------------------
//  in        in    in_valid / in_stall    opcode, data_byte, read_index
//  out       out   out_valid / out_stall  status, telegram_length, read_byte
//  cfg       in    cfg_write              cfg_index, cfg_data
//
//  One beat is accepted per cycle while in_stall is low; line state updates
//  and the store access fall in the accept cycle, any result beat in the next.
//  The single-port telegram store (one write or one read per cycle) sets the
//  one-beat-per-cycle figure; reads return through its registered output.
//  in_stall rises only while a result beat sits in the output register and
//  out_stall is high. The store needs no clearing after reset.
//
module meter_telegram_framer_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mtf_pkg::mtf_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mtf_pkg::mtf_out_t               out_data,
    input  logic                            cfg_write,
    input  logic [mtf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mtf_pkg::*;

    // Configuration registers
    logic [IDLE_W-1:0]     idle_limit_reg;
    logic [MAX_LEN_W-1:0]  max_len_reg;

    // Framing state
    logic                  in_telegram_reg, in_telegram_next;
    logic                  skipping_reg, skipping_next;
    logic [LINE_CNT_W-1:0] line_count_reg, line_count_next;
    logic [7:0]            first_char_reg, first_char_next;
    logic [LEN_W-1:0]      stored_len_reg, stored_len_next;
    logic [IDLE_W-1:0]     idle_count_reg, idle_count_next;

    // Output stage
    logic                  out_valid_reg, out_valid_next;
    mtf_status_t           out_status_reg, out_status_next;
    logic [OUT_LEN_W-1:0]  out_len_reg, out_len_next;
    logic                  out_hit_reg, out_hit_next;

    // Store port
    logic [7:0]            store_mem [TELEGRAM_CAPACITY];
    logic [7:0]            rdata_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [POS_W-1:0]      mem_pos;
    logic [7:0]            mem_wdata;

    // Datapath terms
    logic                  accept;
    logic                  is_eol;
    logic [7:0]            data_first;
    logic [POS_W-1:0]      data_pos;
    logic [POS_W-1:0]      eol_pos;
    logic [POS_W-1:0]      eol_len;
    logic [POS_W-1:0]      rd_pos;
    logic                  eol_too_long;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign is_eol    = (in_data.data_byte == CH_CR) || (in_data.data_byte == CH_LF);

    // First character of the line as seen by a data byte
    assign data_first = (line_count_reg == '0) ? in_data.data_byte : first_char_reg;
    assign data_pos   = ((data_first == CH_START) ? POS_W'(0) : POS_W'(stored_len_reg))
                        + POS_W'(line_count_reg);

    // Line end: newline position and appended length
    assign eol_pos = ((first_char_reg == CH_START) ? POS_W'(0) : POS_W'(stored_len_reg))
                     + POS_W'(line_count_reg);
    assign eol_len = eol_pos + POS_W'(1);
    assign eol_too_long = (CMP_W'(eol_len) > CMP_W'(max_len_reg))
                          || (eol_len > POS_W'(TELEGRAM_CAPACITY));

    assign rd_pos = POS_W'(in_data.read_index);

    // Next state, store access and result
    always_comb
    begin
        in_telegram_next = in_telegram_reg;
        skipping_next    = skipping_reg;
        line_count_next  = line_count_reg;
        first_char_next  = first_char_reg;
        stored_len_next  = stored_len_reg;
        idle_count_next  = idle_count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_len_next     = out_len_reg;
        out_hit_next     = out_hit_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_pos          = '0;
        mem_wdata        = in_data.data_byte;

        if (accept)
        begin
            case (in_data.opcode)
                OP_BYTE:
                begin
                    idle_count_next = '0;
                    if (is_eol)
                    begin
                        line_count_next = '0;
                        if (skipping_reg)
                        begin
                            skipping_next = 1'b0;
                        end
                        else if (line_count_reg != '0)
                        begin
                            if (in_telegram_reg || (first_char_reg == CH_START))
                            begin
                                // newline into the store
                                mem_we    = (eol_pos < POS_W'(TELEGRAM_CAPACITY));
                                mem_pos   = eol_pos;
                                mem_wdata = CH_LF;
                                if (eol_too_long)
                                begin
                                    in_telegram_next = 1'b0;
                                    stored_len_next  = '0;
                                    out_valid_next   = 1'b1;
                                    out_status_next  = ST_DROP;
                                    out_len_next     = '0;
                                    out_hit_next     = 1'b0;
                                end
                                else
                                begin
                                    in_telegram_next = 1'b1;
                                    stored_len_next  = LEN_W'(eol_len);
                                    if (first_char_reg == CH_END)
                                    begin
                                        in_telegram_next = 1'b0;
                                        out_valid_next   = 1'b1;
                                        out_status_next  = ST_DONE;
                                        out_len_next     = OUT_LEN_W'(eol_len);
                                        out_hit_next     = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    else if (line_count_reg == LINE_CNT_W'(LINE_CAPACITY - 1))
                    begin
                        // overlong line: drop the rest
                        skipping_next = 1'b1;
                    end
                    else
                    begin
                        first_char_next = data_first;
                        line_count_next = line_count_reg + LINE_CNT_W'(1);
                        if (in_telegram_reg || (data_first == CH_START))
                        begin
                            mem_we  = (data_pos < POS_W'(TELEGRAM_CAPACITY));
                            mem_pos = data_pos;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (idle_count_reg != '1)
                    begin
                        idle_count_next = idle_count_reg + IDLE_W'(1);
                    end
                    if (in_telegram_reg && (idle_count_reg >= idle_limit_reg))
                    begin
                        in_telegram_next = 1'b0;
                        skipping_next    = 1'b0;
                        line_count_next  = '0;
                        stored_len_next  = '0;
                        out_valid_next   = 1'b1;
                        out_status_next  = ST_IDLE;
                        out_len_next     = '0;
                        out_hit_next     = 1'b0;
                    end
                end
                OP_READ:
                begin
                    mem_re          = 1'b1;
                    mem_pos         = rd_pos;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_READ;
                    out_len_next    = '0;
                    out_hit_next    = (rd_pos < POS_W'(stored_len_reg))
                                      && (rd_pos < POS_W'(TELEGRAM_CAPACITY));
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg  <= IDLE_LIMIT_RST;
            max_len_reg     <= MAX_LEN_RST;
            in_telegram_reg <= 1'b0;
            skipping_reg    <= 1'b0;
            line_count_reg  <= '0;
            first_char_reg  <= '0;
            stored_len_reg  <= '0;
            idle_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_IDLE_LIMIT))
            begin
                idle_limit_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_MAX_LEN))
            begin
                max_len_reg <= cfg_data[MAX_LEN_W-1:0];
            end
            in_telegram_reg <= in_telegram_next;
            skipping_reg    <= skipping_next;
            line_count_reg  <= line_count_next;
            first_char_reg  <= first_char_next;
            stored_len_reg  <= stored_len_next;
            idle_count_reg  <= idle_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_hit_reg    <= out_hit_next;
    end

    // Telegram store: one write or one read per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_pos[STORE_AW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_pos[STORE_AW-1:0]];
        end
    end

    // Output beat
    assign out_valid                = out_valid_reg;
    assign out_data.status          = out_status_reg;
    assign out_data.telegram_length = out_len_reg;
    assign out_data.read_byte       = out_hit_reg ? rdata_reg : 8'h00;

    // Checks
    a_skip_full_line: assert property (@(posedge clk) disable iff (!rst_n)
        skipping_reg |-> (line_count_reg == LINE_CNT_W'(LINE_CAPACITY - 1)))
        else $error("skipping a line that is not full");

    a_len_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        stored_len_reg <= LEN_W'(TELEGRAM_CAPACITY))
        else $error("stored length beyond store");

    a_port_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store written and read in one cycle");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.opcode == OP_READ))
        |=> (out_valid && (out_data.status == ST_READ)))
        else $error("read beat without read result");

    a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != ST_DONE)) |-> (out_data.telegram_length == '0))
        else $error("length on a non-completion result");

endmodule

[test/meter_telegram_framer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// meter_telegram_framer_core_tb: self-checking bench for the telegram framer
// Drives byte, tick, read and unused beats through the valid/stall input
// channel and checks every result beat against an in-bench framer model
// or a fixed probe value. A short directed table comes first, then random
// telegram traffic under several limit settings, random gaps on both channels.
// ----------------------------------------------------------------------------
module meter_telegram_framer_core_tb;

    import mtf_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STUCK_LIMIT = 1000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_BEATS = 80;

    typedef struct {
        mtf_in_t  beat;
        bit       fixed;
        bit       hit;
        mtf_out_t want;
    } probe_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid;
    logic     in_stall;
    mtf_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    mtf_out_t out_data;
    logic     cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Framer model state
    bit              open_tgm = 1'b0;
    bit              skip_ln = 1'b0;
    int unsigned     ln_cnt = 0;
    logic [7:0]      ln_first = 8'h00;
    int unsigned     tgm_len = 0;
    int unsigned     quiet_ticks = 0;
    logic [7:0]      store_img [TELEGRAM_CAPACITY];
    logic [IDLE_W-1:0]    lim_idle = IDLE_LIMIT_RST;
    logic [MAX_LEN_W-1:0] lim_len = MAX_LEN_RST;

    mtf_out_t frames_due[$];
    probe_t   probes[$];
    int       errors = 0;
    int       beats_sent = 0;
    int       results_seen = 0;
    int       stuck = 0;
    bit       steady = 1'b0;

    int unsigned phase_idle [PHASES] = '{1, 5, 65535, 12, 30000, 3};
    int unsigned phase_len  [PHASES] = '{2048, 60, 2, 300, 2048, 150};
    int unsigned phase_wide [PHASES] = '{12, 10, 3, 30, 40, 15};

    meter_telegram_framer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Model of one accepted beat; returns 1 when the beat yields a result
    function automatic bit frame_item(input mtf_in_t it, output mtf_out_t res);
        int unsigned base;
        int unsigned total;
        int unsigned n;
        res = '0;
        if (it.opcode == OP_BYTE) begin
            quiet_ticks = 0;
            if (it.data_byte == CH_CR || it.data_byte == CH_LF) begin
                // line end: a skipped or empty line leaves no trace
                if (skip_ln) begin
                    skip_ln = 1'b0;
                    ln_cnt  = 0;
                    return 1'b0;
                end
                if (ln_cnt == 0)
                    return 1'b0;
                n      = ln_cnt;
                ln_cnt = 0;
                if (ln_first == CH_START) begin
                    open_tgm = 1'b1;
                    base     = 0;
                end
                else
                    base = tgm_len;
                if (!open_tgm)
                    return 1'b0;
                total = base + n + 1;
                if (base + n < TELEGRAM_CAPACITY)
                    store_img[STORE_AW'(base + n)] = CH_LF;
                if (total > lim_len || total > TELEGRAM_CAPACITY) begin
                    open_tgm   = 1'b0;
                    tgm_len    = 0;
                    res.status = ST_DROP;
                    return 1'b1;
                end
                tgm_len = total;
                if (ln_first == CH_END) begin
                    open_tgm            = 1'b0;
                    res.status          = ST_DONE;
                    res.telegram_length = OUT_LEN_W'(total);
                    return 1'b1;
                end
                return 1'b0;
            end
            // line byte: into the store at once if a telegram is open or starting
            if (ln_cnt >= LINE_CAPACITY - 1) begin
                skip_ln = 1'b1;
                return 1'b0;
            end
            if (ln_cnt == 0)
                ln_first = it.data_byte;
            if (open_tgm || ln_first == CH_START) begin
                base = (ln_first == CH_START) ? 0 : tgm_len;
                if (base + ln_cnt < TELEGRAM_CAPACITY)
                    store_img[STORE_AW'(base + ln_cnt)] = it.data_byte;
            end
            ln_cnt++;
            return 1'b0;
        end
        if (it.opcode == OP_TICK) begin
            n = quiet_ticks;
            if (quiet_ticks < 65535)
                quiet_ticks++;
            if (open_tgm && n >= lim_idle) begin
                open_tgm   = 1'b0;
                skip_ln    = 1'b0;
                ln_cnt     = 0;
                tgm_len    = 0;
                res.status = ST_IDLE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (it.opcode == OP_READ) begin
            res.status = ST_READ;
            if (it.read_index < tgm_len)
                res.read_byte = store_img[it.read_index];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic mtf_in_t beat_of(input logic [1:0] op, input logic [7:0] b,
                                        input logic [INDEX_W-1:0] idx);
        mtf_in_t it;
        it.opcode     = op;
        it.data_byte  = b;
        it.read_index = idx;
        return it;
    endfunction

    function automatic void probe_model(input logic [1:0] op, input logic [7:0] b,
                                        input logic [INDEX_W-1:0] idx);
        probe_t pr;
        pr.beat  = beat_of(op, b, idx);
        pr.fixed = 1'b0;
        pr.hit   = 1'b0;
        pr.want  = '0;
        probes.push_back(pr);
    endfunction

    function automatic void probe_fixed(input logic [1:0] op, input logic [7:0] b,
                                        input logic [INDEX_W-1:0] idx, input bit hit,
                                        input mtf_status_t st,
                                        input logic [OUT_LEN_W-1:0] len,
                                        input logic [7:0] rb);
        probe_t pr;
        pr.beat                 = beat_of(op, b, idx);
        pr.fixed                = 1'b1;
        pr.hit                  = hit;
        pr.want.status          = st;
        pr.want.telegram_length = len;
        pr.want.read_byte       = rb;
        probes.push_back(pr);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Line content byte: anything but a line terminator
    function automatic logic [7:0] filler();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (r == CH_CR || r == CH_LF)
            r = 8'h2E;
        return r;
    endfunction

    // First byte of a plain data line
    function automatic logic [7:0] lead_byte();
        logic [7:0] r;
        r = filler();
        if (r == CH_START || r == CH_END)
            r = 8'h31;
        return r;
    endfunction

    function automatic logic [INDEX_W-1:0] read_spot();
        if ($urandom_range(0, 1) == 0 || tgm_len + 2 > 2047)
            return INDEX_W'($urandom_range(0, 2047));
        return INDEX_W'($urandom_range(0, tgm_len + 2));
    endfunction

    task automatic log_error(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    // Present one beat and wait until it is taken
    task automatic drive_beat(input mtf_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (it.opcode != OP_UNUSED)
            beats_sent++;
    endtask

    task automatic feed(input mtf_in_t it);
        mtf_out_t res;
        drive_beat(it);
        if (frame_item(it, res))
            frames_due.push_back(res);
    endtask

    task automatic tick_run(input int n);
        repeat (n)
            feed(beat_of(OP_TICK, 8'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 2047))));
    endtask

    task automatic read_run(input int n);
        repeat (n) feed(beat_of(OP_READ, 8'($urandom_range(0, 255)), read_spot()));
    endtask

    // Byte beat with the odd tick or read slipped in ahead of it
    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < 4)
            tick_run(1);
        if ($urandom_range(0, 99) < 3)
            read_run(1);
        feed(beat_of(OP_BYTE, b, INDEX_W'($urandom_range(0, 2047))));
    endtask

    // One line of the given width, then a random terminator style
    task automatic send_line(input logic [7:0] first, input int wide);
        int k;
        put_byte(first);
        for (k = 1; k < wide; k++)
            put_byte(filler());
        case ($urandom_range(0, 3))
            0: begin put_byte(CH_CR); put_byte(CH_LF); end
            1: put_byte(CH_LF);
            2: put_byte(CH_CR);
            default: begin put_byte(CH_CR); put_byte(CH_LF); put_byte(CH_LF); end
        endcase
    endtask

    task automatic send_telegram(input int nlines, input int wide);
        send_line(CH_START, $urandom_range(1, wide));
        repeat (nlines) send_line(lead_byte(), $urandom_range(1, wide));
        send_line(CH_END, $urandom_range(1, wide));
    endtask

    // Hold the sender until every expected result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(input int unsigned idle, input int unsigned maxlen);
        cfg_write <= 1'b1;
        cfg_index <= REG_IDLE_LIMIT;
        cfg_data  <= CFG_DATA_W'(idle);
        @(posedge clk);
        cfg_index <= REG_MAX_LEN;
        cfg_data  <= CFG_DATA_W'(maxlen);
        @(posedge clk);
        cfg_write <= 1'b0;
        lim_idle = IDLE_W'(idle);
        lim_len  = MAX_LEN_W'(maxlen);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        mtf_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (frames_due.size() == 0)
                log_error($sformatf("result %0d: nothing expected, status %0d",
                                    results_seen, out_data.status));
            else begin
                want = frames_due.pop_front();
                if (out_data.status !== want.status)
                    log_error($sformatf("result %0d: status %0d, expected %0d",
                                        results_seen, out_data.status, want.status));
                if (out_data.telegram_length !== want.telegram_length)
                    log_error($sformatf("result %0d: length %0d, expected %0d", results_seen,
                                        out_data.telegram_length, want.telegram_length));
                if (out_data.read_byte !== want.read_byte)
                    log_error($sformatf("result %0d: byte %02h, expected %02h",
                                        results_seen, out_data.read_byte, want.read_byte));
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else begin
                stuck++;
                if (stuck >= STUCK_LIMIT) begin
                    $display("meter_telegram_framer_core_tb: errors");
                    $finish;
                end
            end
        end
    end

    // Result side stalls
    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        mtf_out_t res;
        int       mark;
        int       pick;
        int       wide;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty store, a short telegram with zero and 0xFF bytes,
        // out-of-range reads, the unused opcode and an open telegram
        probe_fixed(OP_READ, 8'h00, 11'd0, 1'b1, ST_READ, 12'd0, 8'h00);
        probe_fixed(OP_READ, 8'hFF, 11'd2047, 1'b1, ST_READ, 12'd0, 8'h00);
        probe_fixed(OP_TICK, 8'h00, 11'd0, 1'b0, ST_DONE, 12'd0, 8'h00);
        probe_model(OP_BYTE, 8'h78, 11'd0);
        probe_model(OP_BYTE, CH_CR, 11'd0);
        probe_model(OP_BYTE, CH_LF, 11'd0);
        probe_model(OP_BYTE, CH_START, 11'd0);
        probe_model(OP_BYTE, 8'h00, 11'd0);
        probe_model(OP_BYTE, 8'hFF, 11'd2047);
        probe_model(OP_BYTE, CH_CR, 11'd0);
        probe_model(OP_BYTE, CH_LF, 11'd0);
        probe_model(OP_BYTE, CH_END, 11'd0);
        probe_fixed(OP_BYTE, CH_LF, 11'd0, 1'b1, ST_DONE, 12'd6, 8'h00);
        probe_fixed(OP_READ, 8'h00, 11'd0, 1'b1, ST_READ, 12'd0, CH_START);
        probe_fixed(OP_READ, 8'h00, 11'd2, 1'b1, ST_READ, 12'd0, 8'hFF);
        probe_fixed(OP_READ, 8'h00, 11'd3, 1'b1, ST_READ, 12'd0, CH_LF);
        probe_fixed(OP_READ, 8'h00, 11'd5, 1'b1, ST_READ, 12'd0, CH_LF);
        probe_fixed(OP_READ, 8'h00, 11'd6, 1'b1, ST_READ, 12'd0, 8'h00);
        probe_fixed(OP_UNUSED, 8'hFF, 11'd2047, 1'b0, ST_DONE, 12'd0, 8'h00);
        probe_model(OP_BYTE, CH_START, 11'd0);
        probe_model(OP_BYTE, CH_CR, 11'd0);
        probe_model(OP_TICK, 8'h00, 11'd0);
        probe_model(OP_READ, 8'h00, 11'd1);
        probe_model(OP_BYTE, 8'h55, 11'd0);
        probe_model(OP_BYTE, CH_LF, 11'd0);

        foreach (probes[i]) begin
            if (probes[i].fixed) begin
                drive_beat(probes[i].beat);
                void'(frame_item(probes[i].beat, res));
                if (probes[i].hit)
                    frames_due.push_back(probes[i].want);
            end
            else
                feed(probes[i].beat);
        end

        // Random traffic under each limit setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_limits(phase_idle[p], phase_len[p]);
            wide = phase_wide[p];
            mark = beats_sent;
            while (beats_sent - mark < PHASE_BEATS) begin
                if ($urandom_range(0, 9) == 0)
                    steady = !steady;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_telegram($urandom_range(0, 4), wide);
                else if (pick < 70) begin
                    // telegram left open: idle out, or restarted by the next one
                    send_line(CH_START, $urandom_range(1, wide));
                    if ($urandom_range(0, 1) == 0)
                        send_line(lead_byte(), $urandom_range(1, wide));
                    if (lim_idle <= 20)
                        tick_run(lim_idle + $urandom_range(1, 3));
                end
                else if (pick < 80)
                    tick_run($urandom_range(1, 8));
                else if (pick < 90)
                    read_run($urandom_range(1, 6));
                else if (pick < 97)
                    repeat ($urandom_range(1, 8))
                        feed(beat_of(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                     INDEX_W'($urandom_range(0, 2047))));
                else
                    drain();
            end
            if (p == 4) begin
                steady = 1'b0;
                // overlong data line inside an open telegram is skipped
                send_line(CH_START, 20);
                send_line(lead_byte(), 1026);
                send_line(CH_END, 5);
                read_run(8);
            end
        end
        steady = 1'b0;

        drain();
        if (frames_due.size() != 0)
            log_error($sformatf("%0d results never arrived", frames_due.size()));
        if (errors == 0)
            $display("meter_telegram_framer_core_tb: clean");
        else
            $display("meter_telegram_framer_core_tb: errors");
        $finish;
    end

endmodule
